/* src/modbus_rtu_master_frame_engine_core_assert.svh */
`ifndef MODBUS_RTU_MASTER_FRAME_ENGINE_CORE_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAME_ENGINE_CORE_ASSERT_SVH

// expression holds at every clock edge out of reset
`define MBRTU_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("frame engine invariant violated");

// consequent holds in the same cycle as the antecedent
`define MBRTU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame engine implication violated");

// consequent holds in the cycle after the antecedent
`define MBRTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame engine sequence violated");

`endif

/* src/mbrtu_pkg.sv */
package mbrtu_pkg;

   localparam int FRAME_LEN = 8;
   localparam int RX_DEPTH  = 9;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [7:0] FUNC_READ      = 8'h03;
   localparam logic [7:0] FUNC_WRITE     = 8'h06;
   localparam logic [7:0] BYTE_COUNT_ONE = 8'h02;
   localparam logic [7:0] QTY_HIGH       = 8'h00;
   localparam logic [7:0] QTY_ONE        = 8'h01;
   localparam logic [7:0] QTY_TWO        = 8'h02;

   localparam logic [1:0] WORDS_TWO = 2'd2;

   localparam logic [2:0] CRC_LO_POS = 3'd6;
   localparam logic [2:0] CRC_HI_POS = 3'd7;

   localparam logic [3:0] LEN_READ1 = 4'd7;
   localparam logic [3:0] LEN_READ2 = 4'd9;
   localparam logic [3:0] LEN_WRITE = 4'd8;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;

   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RX      = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_TIMEOUT = 3'd1,
      STATUS_HEADER  = 3'd2,
      STATUS_CRC     = 3'd3,
      STATUS_ECHO    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PEND_IDLE  = 2'd0,
      PEND_READ1 = 2'd1,
      PEND_READ2 = 2'd2,
      PEND_WRITE = 2'd3
   } pending_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] register_address;
      logic [15:0] write_value;
      logic [1:0]  word_count;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      status_type  status;
      logic [31:0] read_value;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/modbus_rtu_master_frame_engine_core.sv */
// Modbus RTU master frame engine. A read or write request item is turned into an 8-byte
// request frame (CRC-16 low byte first) that leaves as eight transmit results, one per cycle
// while rsp_stall is low; reply bytes are then gathered and the last expected byte, or a
// timeout item, yields one completion result with status and read data. Items pass an input
// register and short logic into a single result register. A request blocks the next item
// until its frame bytes have left through the result register one at a time, with the
// frame CRC folded in byte by byte. The input register takes the next item while a result
// still waits. Write the device address only while no transaction is in flight.
`include "modbus_rtu_master_frame_engine_core_assert.svh"

module modbus_rtu_master_frame_engine_core
   import mbrtu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]  dev_addr_ff;
   logic        req_valid_ff, req_valid_in;
   req_type     req_ff;
   pending_type pending_ff, pending_in;
   logic [3:0]  rx_count_ff, rx_count_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic [2:0]  tx_idx_ff, tx_idx_in;
   logic [7:0]  rx_bytes_ff [RX_DEPTH];
   logic [7:0]  rx_bytes_in [RX_DEPTH];
   logic [7:0]  frame_ff [FRAME_LEN];
   logic [7:0]  frame_in [FRAME_LEN];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        slot_free, fire, emit, is_request, rx_active, rx_done, timeout_done;
   logic [3:0]  rx_len, rx_pos;
   logic        hdr_ok, echo_ok;
   logic [15:0] got_crc;
   status_type  done_status;
   logic [31:0] done_value;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign fire       = req_valid_ff && slot_free && (tx_idx_ff == 3'd0);
   assign emit       = (tx_idx_ff != 3'd0) && slot_free;
   assign req_stall  = req_valid_ff && !fire;
   assign is_request = (req_ff.op == OP_READ) || (req_ff.op == OP_WRITE);
   assign rx_active  = fire && (req_ff.op == OP_RX) && (pending_ff != PEND_IDLE);
   assign timeout_done = fire && (req_ff.op == OP_TIMEOUT) && (pending_ff != PEND_IDLE);

   always_comb begin
      unique case (pending_ff)
         PEND_READ1: rx_len = LEN_READ1;
         PEND_READ2: rx_len = LEN_READ2;
         PEND_WRITE: rx_len = LEN_WRITE;
         PEND_IDLE:  rx_len = LEN_WRITE;
      endcase
   end

   assign rx_pos  = (rx_count_ff >= rx_len) ? rx_len - 4'd1 : rx_count_ff;
   assign rx_done = rx_active && ((rx_pos + 4'd1) == rx_len);

   always_comb begin
      req_valid_in = req_valid_ff;
      if (fire) begin
         req_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         req_valid_in = 1'b1;
      end
   end

   // next state of the pending transaction
   always_comb begin
      pending_in = pending_ff;
      if (fire) begin
         unique case (req_ff.op)
            OP_READ:    pending_in = (req_ff.word_count == WORDS_TWO) ? PEND_READ2 : PEND_READ1;
            OP_WRITE:   pending_in = PEND_WRITE;
            OP_TIMEOUT: pending_in = PEND_IDLE;
            OP_RX: begin
               if (rx_done) begin
                  pending_in = PEND_IDLE;
               end
            end
         endcase
      end
   end

   // reply collection and checks
   always_comb begin
      rx_bytes_in = rx_bytes_ff;
      rx_count_in = rx_count_ff;
      rx_crc_in   = rx_crc_ff;
      if (rx_active) begin
         rx_bytes_in[rx_pos] = req_ff.rx_byte;
         if (rx_pos < (rx_len - 4'd2)) begin
            rx_crc_in = crc_byte(rx_crc_ff, req_ff.rx_byte);
         end
         rx_count_in = rx_pos + 4'd1;
      end
      if ((fire && (is_request || req_ff.op == OP_TIMEOUT)) || rx_done) begin
         rx_count_in = 4'd0;
         rx_crc_in   = CRC_INIT;
      end
   end

   always_comb begin
      hdr_ok = (rx_bytes_in[0] == frame_ff[0]) && (rx_bytes_in[1] == FUNC_READ) &&
               ((pending_ff != PEND_READ1) || (rx_bytes_in[2] == BYTE_COUNT_ONE));
      got_crc = (pending_ff == PEND_READ2) ? {rx_bytes_in[8], rx_bytes_in[7]}
                                           : {rx_bytes_in[6], rx_bytes_in[5]};
      echo_ok = (rx_bytes_in[0] == frame_ff[0]) && (rx_bytes_in[1] == frame_ff[1]) &&
                (rx_bytes_in[2] == frame_ff[2]) && (rx_bytes_in[3] == frame_ff[3]) &&
                (rx_bytes_in[4] == frame_ff[4]) && (rx_bytes_in[5] == frame_ff[5]) &&
                (rx_bytes_in[6] == frame_ff[6]) && (rx_bytes_in[7] == frame_ff[7]);
      done_status = STATUS_OK;
      done_value  = 32'd0;
      if (pending_ff == PEND_WRITE) begin
         if (!echo_ok) begin
            done_status = STATUS_ECHO;
         end
      end else if (!hdr_ok) begin
         done_status = STATUS_HEADER;
      end else if (got_crc != rx_crc_ff) begin
         done_status = STATUS_CRC;
      end else if (pending_ff == PEND_READ1) begin
         done_value = {16'd0, rx_bytes_in[3], rx_bytes_in[4]};
      end else begin
         done_value = {rx_bytes_in[3], rx_bytes_in[4], rx_bytes_in[5], rx_bytes_in[6]};
      end
   end

   // request frame build and byte emission
   always_comb begin
      frame_in     = frame_ff;
      tx_crc_in    = tx_crc_ff;
      tx_idx_in    = tx_idx_ff;
      rsp_valid_in = rsp_valid_ff && !slot_free;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = KIND_TX;
         rsp_in.last        = (tx_idx_ff == CRC_HI_POS);
         rsp_in.status      = STATUS_OK;
         rsp_in.read_value  = 32'd0;
         rsp_in.tx_byte     = frame_ff[tx_idx_ff];
         tx_idx_in          = tx_idx_ff + 3'd1;
         if (tx_idx_ff == CRC_LO_POS) begin
            frame_in[CRC_LO_POS] = tx_crc_ff[7:0];
            frame_in[CRC_HI_POS] = tx_crc_ff[15:8];
            rsp_in.tx_byte       = tx_crc_ff[7:0];
         end else if (tx_idx_ff != CRC_HI_POS) begin
            tx_crc_in = crc_byte(tx_crc_ff, frame_ff[tx_idx_ff]);
         end
      end else if (fire && is_request) begin
         frame_in[0] = dev_addr_ff;
         frame_in[2] = req_ff.register_address[15:8];
         frame_in[3] = req_ff.register_address[7:0];
         if (req_ff.op == OP_READ) begin
            frame_in[1] = FUNC_READ;
            frame_in[4] = QTY_HIGH;
            frame_in[5] = (req_ff.word_count == WORDS_TWO) ? QTY_TWO : QTY_ONE;
         end else begin
            frame_in[1] = FUNC_WRITE;
            frame_in[4] = req_ff.write_value[15:8];
            frame_in[5] = req_ff.write_value[7:0];
         end
         tx_crc_in         = crc_byte(CRC_INIT, dev_addr_ff);
         tx_idx_in         = 3'd1;
         rsp_valid_in      = 1'b1;
         rsp_in.kind       = KIND_TX;
         rsp_in.tx_byte    = dev_addr_ff;
         rsp_in.last       = 1'b0;
         rsp_in.status     = STATUS_OK;
         rsp_in.read_value = 32'd0;
      end else if (rx_done || timeout_done) begin
         rsp_valid_in      = 1'b1;
         rsp_in.kind       = KIND_DONE;
         rsp_in.tx_byte    = 8'd0;
         rsp_in.last       = 1'b0;
         rsp_in.status     = timeout_done ? STATUS_TIMEOUT : done_status;
         rsp_in.read_value = timeout_done ? 32'd0 : done_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DEVICE_ADDRESS_RESET;
         req_valid_ff <= 1'b0;
         pending_ff   <= PEND_IDLE;
         rx_count_ff  <= 4'd0;
         rx_crc_ff    <= CRC_INIT;
         tx_idx_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dev_addr_ff <= csr_wr_data;
         end
         req_valid_ff <= req_valid_in;
         pending_ff   <= pending_in;
         rx_count_ff  <= rx_count_in;
         rx_crc_ff    <= rx_crc_in;
         tx_idx_ff    <= tx_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      tx_crc_ff   <= tx_crc_in;
      rx_bytes_ff <= rx_bytes_in;
      frame_ff    <= frame_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MBRTU_ASSERT_IMPLIES(a_frame_busy_has_result, clock, reset, tx_idx_ff != 3'd0, rsp_valid_ff)
   `MBRTU_ASSERT_IMPLIES(a_last_ends_frame, clock, reset, rsp_valid_ff && rsp_ff.last, tx_idx_ff == 3'd0)
   `MBRTU_ASSERT_NEXT(a_request_starts_frame, clock, reset, fire && is_request, tx_idx_ff == 3'd1)
   `MBRTU_ASSERT_HOLDS(a_count_in_range, clock, reset, rx_count_ff < rx_len)

endmodule
